### rtl/riff_wav_stream_parser_macros.svh
// Assertion macros shared by the RIFF/WAVE stream parser RTL.
// Every macro expects signals named clk and arst_n in the including module.
`ifndef RIFF_WAV_STREAM_PARSER_MACROS_SVH
`define RIFF_WAV_STREAM_PARSER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RWP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define RWP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rwp_pkg.sv
// Package for the RIFF/WAVE stream parser: status codes, tags, sizes and
// the word type passed from the front parser to the back end. No dependencies.
`timescale 1ns / 1ps

package rwp_pkg;

	// Final status codes
	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SHORT     = 4'd1,
		ST_TAGS      = 4'd2,
		ST_TRUNC     = 4'd3,
		ST_FMT_SHORT = 4'd4,
		ST_NO_FMT    = 4'd5,
		ST_NO_DATA   = 4'd6,
		ST_UNSUPP    = 4'd7,
		ST_EMPTY     = 4'd8
	} status_t;

	// Little-endian tags as they sit in a 32-bit word
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// File layout
	localparam int MIN_FILE_BYTES    = 44;
	localparam int RIFF_TAG_END      = 3;
	localparam int WAVE_TAG_END      = 11;
	localparam int FMT_MIN_SIZE      = 16;
	localparam int FMT_CAPTURE_BYTES = 16;
	localparam int OFS_W             = $clog2(MIN_FILE_BYTES + 1);

	// Format values accepted
	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] PCM_BITS     = 16'd16;
	localparam logic [15:0] MIN_CHANNELS = 16'd1;
	localparam logic [15:0] MAX_CHANNELS = 16'd2;

	// Default depth of the queue between front and back
	localparam int RWP_QUEUE_DEPTH = 2;

	// One classified byte on its way to the back end
	typedef struct packed {
		logic [7:0] data;
		logic       pay_valid;
		logic       pay_start;
		logic       fmt_wr;
		logic [3:0] fmt_idx;
		logic       last;
		status_t    pre_status;
		logic       data_empty;
	} rwp_word_t;

endpackage

### rtl/rwp_front.sv
// Front parser: walks the RIFF header and chunk headers one byte at a time
// and classifies each byte into an rwp_word_t. Depends on rwp_pkg.
`timescale 1ns / 1ps
`include "riff_wav_stream_parser_macros.svh"

module rwp_front import rwp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] file_byte,
	input  logic       is_last,
	output rwp_word_t  word
);

	typedef enum logic [2:0] {
		PH_FILEHDR,
		PH_CHUNKHDR,
		PH_PAYLOAD,
		PH_PAD,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_FMT,
		KIND_DATA,
		KIND_FMT_SHORT
	} kind_t;

	phase_t           phase_q, phase_d;
	kind_t            kind_q, kind_d;
	logic [OFS_W-1:0] ofs_q, ofs_d;
	logic [63:0]      hdr_q, hdr_d;
	logic [2:0]       hcnt_q, hcnt_d;
	logic [31:0]      rem_q, rem_d;
	logic             pad_q, pad_d;
	logic [4:0]       fidx_q, fidx_d;
	logic             found_fmt_q, found_fmt_d;
	logic             found_data_q, found_data_d;
	logic             empty_q, empty_d;
	status_t          err_q, err_d;
	logic [63:0]      hdr_sh;
	logic [31:0]      hdr_size;

	// Next-state logic and byte classification
	always_comb begin
		phase_d      = phase_q;
		kind_d       = kind_q;
		hdr_d        = hdr_q;
		hcnt_d       = hcnt_q;
		rem_d        = rem_q;
		pad_d        = pad_q;
		fidx_d       = fidx_q;
		found_fmt_d  = found_fmt_q;
		found_data_d = found_data_q;
		empty_d      = empty_q;
		err_d        = err_q;
		hdr_sh       = {file_byte, hdr_q[63:8]};
		hdr_size     = hdr_sh[63:32];

		word            = '0;
		word.last       = is_last;
		word.pre_status = ST_OK;

		// saturating file offset, only needs to reach the minimum length
		ofs_d = (ofs_q == OFS_W'(MIN_FILE_BYTES)) ? ofs_q : ofs_q + 1'b1;

		case (phase_q)
			PH_FILEHDR: begin
				hdr_d = hdr_sh;
				if (ofs_q == OFS_W'(RIFF_TAG_END) && hdr_sh[63:32] != TAG_RIFF) begin
					if (err_q == ST_OK) err_d = ST_TAGS;
					phase_d = PH_STOP;
				end else if (ofs_q == OFS_W'(WAVE_TAG_END)) begin
					if (hdr_sh[63:32] != TAG_WAVE) begin
						if (err_q == ST_OK) err_d = ST_TAGS;
						phase_d = PH_STOP;
					end else begin
						phase_d = PH_CHUNKHDR;
						hcnt_d  = '0;
					end
				end
			end
			PH_CHUNKHDR: begin
				hdr_d  = hdr_sh;
				hcnt_d = hcnt_q + 1'b1;
				if (hcnt_q == '1) begin
					fidx_d = '0;
					if (hdr_sh[31:0] == TAG_FMT) begin
						if (hdr_size >= 32'(FMT_MIN_SIZE)) begin
							kind_d      = KIND_FMT;
							found_fmt_d = 1'b1;
						end else begin
							kind_d = KIND_FMT_SHORT;
						end
					end else if (hdr_sh[31:0] == TAG_DATA) begin
						kind_d       = KIND_DATA;
						found_data_d = 1'b1;
						empty_d      = (hdr_size == '0);
					end else begin
						kind_d = KIND_OTHER;
					end
					if (hdr_size == '0) begin
						if (kind_d == KIND_FMT_SHORT) begin
							if (err_q == ST_OK) err_d = ST_FMT_SHORT;
							phase_d = PH_STOP;
						end
					end else begin
						rem_d   = hdr_size;
						pad_d   = hdr_size[0];
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (kind_q == KIND_FMT && fidx_q < 5'(FMT_CAPTURE_BYTES)) begin
					word.fmt_wr  = 1'b1;
					word.fmt_idx = fidx_q[3:0];
					word.data    = file_byte;
				end
				if (kind_q == KIND_DATA) begin
					word.pay_valid = 1'b1;
					word.pay_start = (fidx_q == '0);
					word.data      = file_byte;
				end
				if (fidx_q < 5'(FMT_CAPTURE_BYTES)) fidx_d = fidx_q + 1'b1;
				rem_d = rem_q - 1'b1;
				if (rem_q == 32'd1) begin
					if (kind_q == KIND_FMT_SHORT) begin
						if (err_q == ST_OK) err_d = ST_FMT_SHORT;
						phase_d = PH_STOP;
					end else begin
						phase_d = pad_q ? PH_PAD : PH_CHUNKHDR;
						pad_d   = 1'b0;
					end
				end
			end
			PH_PAD: begin
				pad_d   = 1'b0;
				phase_d = PH_CHUNKHDR;
			end
			default: begin
				// stopped on an error: consume and drop
			end
		endcase

		// Early part of the final status; format checks finish in the back end
		if (is_last) begin
			word.data_empty = empty_d;
			if (ofs_d < OFS_W'(MIN_FILE_BYTES)) word.pre_status = ST_SHORT;
			else if (err_d != ST_OK)            word.pre_status = err_d;
			else if (phase_d == PH_PAYLOAD)     word.pre_status = ST_TRUNC;
			else if (!found_fmt_d)              word.pre_status = ST_NO_FMT;
			else if (!found_data_d)             word.pre_status = ST_NO_DATA;
		end
	end

	// Hold parser state; restart after the last byte of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FILEHDR;
			kind_q       <= KIND_OTHER;
			ofs_q        <= '0;
			hdr_q        <= '0;
			hcnt_q       <= '0;
			rem_q        <= '0;
			pad_q        <= 1'b0;
			fidx_q       <= '0;
			found_fmt_q  <= 1'b0;
			found_data_q <= 1'b0;
			empty_q      <= 1'b0;
			err_q        <= ST_OK;
		end else if (accept) begin
			if (is_last) begin
				phase_q      <= PH_FILEHDR;
				kind_q       <= KIND_OTHER;
				ofs_q        <= '0;
				hdr_q        <= '0;
				hcnt_q       <= '0;
				rem_q        <= '0;
				pad_q        <= 1'b0;
				fidx_q       <= '0;
				found_fmt_q  <= 1'b0;
				found_data_q <= 1'b0;
				empty_q      <= 1'b0;
				err_q        <= ST_OK;
			end else begin
				phase_q      <= phase_d;
				kind_q       <= kind_d;
				ofs_q        <= ofs_d;
				hdr_q        <= hdr_d;
				hcnt_q       <= hcnt_d;
				rem_q        <= rem_d;
				pad_q        <= pad_d;
				fidx_q       <= fidx_d;
				found_fmt_q  <= found_fmt_d;
				found_data_q <= found_data_d;
				empty_q      <= empty_d;
				err_q        <= err_d;
			end
		end
	end

	`RWP_ASSERT_IMPL(a_stop_has_err, phase_q == PH_STOP, err_q != ST_OK, "stopped without error")
	`RWP_ASSERT_NEXT(a_err_sticky, err_q != ST_OK && !(accept && is_last), err_q == $past(err_q), "latched error changed")

endmodule

### rtl/rwp_queue.sv
// Short register queue of classified words between the front parser and
// the back end. Depends on rwp_pkg.
`timescale 1ns / 1ps
`include "riff_wav_stream_parser_macros.svh"

module rwp_queue import rwp_pkg::*; #(
	parameter int DEPTH = RWP_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rwp_word_t push_word,
	output logic      full,
	input  logic      pop,
	output logic      nonempty,
	output rwp_word_t pop_word
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rwp_word_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_word = slot_q[rd_ptr_q];

	// Store incoming words
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_word;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`RWP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count overflow")
	`RWP_ASSERT_NEXT(a_cnt_drop, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1, "pop lost")

endmodule

### rtl/rwp_back.sv
// Back end: captures fmt fields, finishes the final status and holds the
// output register. Depends on rwp_pkg.
`timescale 1ns / 1ps
`include "riff_wav_stream_parser_macros.svh"

module rwp_back import rwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	input  rwp_word_t   word,
	output logic        word_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        payload_start,
	output logic        done_res,
	output logic [3:0]  status,
	output logic [15:0] format_tag,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [31:0] byte_rate,
	output logic [15:0] block_align,
	output logic [15:0] sample_bits
);

	logic [127:0] fields_q, fields_d;
	logic         out_valid_q;
	logic         load;
	status_t      fin_status;
	logic [15:0]  f_tag, f_chans, f_bits;
	logic         unsupported;

	assign load     = !out_valid_q || !out_stall;
	assign word_pop = word_valid && load;

	// Merge this byte into the fmt fields and finish the status
	always_comb begin
		fields_d = fields_q;
		if (word.fmt_wr) fields_d[{word.fmt_idx, 3'b000} +: 8] = word.data;
		f_tag       = fields_d[15:0];
		f_chans     = fields_d[31:16];
		f_bits      = fields_d[127:112];
		unsupported = (f_tag != FMT_PCM) || (f_bits != PCM_BITS) ||
			(f_chans < MIN_CHANNELS) || (f_chans > MAX_CHANNELS);
		if (word.pre_status != ST_OK) fin_status = word.pre_status;
		else if (unsupported)         fin_status = ST_UNSUPP;
		else if (word.data_empty)     fin_status = ST_EMPTY;
		else                          fin_status = ST_OK;
	end

	// Hold captured fields; clear them after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_q <= '0;
		end else if (word_pop) begin
			fields_q <= word.last ? '0 : fields_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_pop) begin
			payload_valid <= word.pay_valid;
			payload_byte  <= word.pay_valid ? word.data : 8'd0;
			payload_start <= word.pay_start;
			done_res      <= word.last;
			if (word.last) begin
				status        <= fin_status;
				format_tag    <= fields_d[15:0];
				channel_count <= fields_d[31:16];
				sample_rate   <= fields_d[63:32];
				byte_rate     <= fields_d[95:64];
				block_align   <= fields_d[111:96];
				sample_bits   <= fields_d[127:112];
			end else begin
				status        <= ST_OK;
				format_tag    <= '0;
				channel_count <= '0;
				sample_rate   <= '0;
				byte_rate     <= '0;
				block_align   <= '0;
				sample_bits   <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`RWP_ASSERT_IMPL(a_byte_zero, out_valid_q && !payload_valid, payload_byte == 8'd0, "stray payload byte")
	`RWP_ASSERT_IMPL(a_status_idle, out_valid_q && !done_res, status == ST_OK && sample_rate == 32'd0, "status before done")

endmodule

### rtl/riff_wav_stream_parser.sv
// Top level of the RIFF/WAVE stream parser: front parser, word queue and
// back end. Depends on rwp_pkg, rwp_front, rwp_queue and rwp_back.
`timescale 1ns / 1ps

// Usage:
// Input channel: file_byte and is_last with in_valid / in_stall. One byte of
// the WAV file per word, is_last high on its final byte; the next byte then
// starts a new file.
// Output channel: one result word per input byte with out_valid / out_stall.
// payload_valid/payload_byte/payload_start tag data-chunk payload; done_res
// marks the word of the last byte, which carries status and the captured
// fmt fields (all zero on other words). Discard payload unless status is 0.
// Path: an accepted byte goes into the queue and then into the back end's
// output register. Throughput: one byte per cycle while in_stall is low, set
// by the front parser; the back end drains one word per cycle when not stalled.
// Stalls: the queue between front and back absorbs a stall of the receiver;
// in_stall rises once the queue is full and falls as soon as a word leaves.
// Reset: arst_n clears the parser, queue and output; the first byte after
// reset is byte 0 of a file.
module riff_wav_stream_parser import rwp_pkg::*; #(
	parameter int QUEUE_DEPTH = RWP_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  file_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        payload_start,
	output logic        done_res,
	output logic [3:0]  status,
	output logic [15:0] format_tag,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [31:0] byte_rate,
	output logic [15:0] block_align,
	output logic [15:0] sample_bits
);

	rwp_word_t front_word, back_word;
	logic      accept, q_full, q_nonempty, q_pop;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	rwp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.file_byte (file_byte),
		.is_last   (is_last),
		.word      (front_word)
	);

	rwp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (front_word),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_word  (back_word)
	);

	rwp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.word_valid    (q_nonempty),
		.word          (back_word),
		.word_pop      (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.payload_start (payload_start),
		.done_res      (done_res),
		.status        (status),
		.format_tag    (format_tag),
		.channel_count (channel_count),
		.sample_rate   (sample_rate),
		.byte_rate     (byte_rate),
		.block_align   (block_align),
		.sample_bits   (sample_bits)
	);

endmodule

### tb/sv/wav_tb_pkg.sv
`timescale 1ns / 1ps
// Result board for the RIFF/WAVE stream parser bench: a byte-level model of the
// parser that predicts every result word, and the queue of words still due.
// Depends on rwp_pkg for status codes, tags and file layout constants.

package wav_tb_pkg;
	import rwp_pkg::*;

	typedef enum logic [2:0] {
		PH_FILE_HDR,
		PH_CHUNK_HDR,
		PH_BODY,
		PH_PAD_BYTE,
		PH_HALTED
	} walk_phase_e;

	typedef enum logic [1:0] {
		CK_OTHER,
		CK_FMT,
		CK_DATA,
		CK_FMT_SHORT
	} chunk_kind_e;

	// One result word, fields in port order
	typedef struct packed {
		logic        pay_valid;
		logic [7:0]  pay_byte;
		logic        pay_start;
		logic        done;
		logic [3:0]  st;
		logic [15:0] fmt_tag;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [31:0] brate;
		logic [15:0] align;
		logic [15:0] bits;
	} wav_word_t;

	class wav_result_board;
		int          errors;
		wav_word_t   due_words[$];
		walk_phase_e phase;
		chunk_kind_e kind;
		logic [31:0] offset;
		logic [31:0] remain;
		logic [63:0] shreg;
		logic [63:0] fmt_lo;
		logic [63:0] fmt_hi;
		logic [4:0]  fmt_idx;
		int          hdr_n;
		logic        pad_due;
		logic        have_fmt;
		logic        have_data;
		logic        data_empty;
		status_t     err;

		function new();
			errors = 0;
			rewind();
		endfunction

		// Return the walk to the start of a file
		function void rewind();
			phase      = PH_FILE_HDR;
			kind       = CK_OTHER;
			offset     = '0;
			remain     = '0;
			shreg      = '0;
			fmt_lo     = '0;
			fmt_hi     = '0;
			fmt_idx    = '0;
			hdr_n      = 0;
			pad_due    = 1'b0;
			have_fmt   = 1'b0;
			have_data  = 1'b0;
			data_empty = 1'b0;
			err        = ST_OK;
		endfunction

		// Keep the first error and stop parsing the rest of the file
		function void halt(status_t code);
			if (err == ST_OK)
				err = code;
			phase = PH_HALTED;
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		// Advance the parser by one accepted byte and queue the word it yields
		function void note_byte(logic [7:0] b, logic last);
			wav_word_t   w;
			logic [31:0] id;
			logic [31:0] size;
			status_t     st;
			w = '0;
			case (phase)
				PH_FILE_HDR: begin
					if (offset[1:0] == 2'd0)
						shreg = '0;
					shreg[8*offset[1:0] +: 8] = b;
					if (offset[1:0] == 2'd3) begin
						if (offset == RIFF_TAG_END && shreg[31:0] != TAG_RIFF) begin
							halt(ST_TAGS);
						end else if (offset == WAVE_TAG_END) begin
							if (shreg[31:0] != TAG_WAVE) begin
								halt(ST_TAGS);
							end else begin
								phase = PH_CHUNK_HDR;
								hdr_n = 0;
								shreg = '0;
							end
						end
					end
				end
				PH_CHUNK_HDR: begin
					shreg[8*hdr_n +: 8] = b;
					hdr_n++;
					if (hdr_n >= 8) begin
						id      = shreg[31:0];
						size    = shreg[63:32];
						hdr_n   = 0;
						shreg   = '0;
						fmt_idx = '0;
						if (id == TAG_FMT) begin
							if (size >= FMT_MIN_SIZE) begin
								kind     = CK_FMT;
								have_fmt = 1'b1;
							end else begin
								kind = CK_FMT_SHORT;
							end
						end else if (id == TAG_DATA) begin
							kind       = CK_DATA;
							have_data  = 1'b1;
							data_empty = (size == 0);
						end else begin
							kind = CK_OTHER;
						end
						// an empty chunk goes straight to the next header; an empty short fmt chunk halts
						if (size == 0) begin
							if (kind == CK_FMT_SHORT)
								halt(ST_FMT_SHORT);
						end else begin
							remain  = size;
							pad_due = size[0];
							phase   = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					if (kind == CK_FMT && fmt_idx < FMT_CAPTURE_BYTES) begin
						if (fmt_idx < 8)
							fmt_lo[8*fmt_idx[2:0] +: 8] = b;
						else
							fmt_hi[8*fmt_idx[2:0] +: 8] = b;
					end
					if (kind == CK_DATA) begin
						w.pay_valid = 1'b1;
						w.pay_byte  = b;
						w.pay_start = (fmt_idx == 0);
					end
					if (fmt_idx < FMT_CAPTURE_BYTES)
						fmt_idx++;
					remain--;
					if (remain == 0) begin
						if (kind == CK_FMT_SHORT) begin
							halt(ST_FMT_SHORT);
						end else begin
							phase   = pad_due ? PH_PAD_BYTE : PH_CHUNK_HDR;
							pad_due = 1'b0;
						end
					end
				end
				PH_PAD_BYTE: begin
					pad_due = 1'b0;
					phase   = PH_CHUNK_HDR;
				end
				default: begin
				end
			endcase

			if (offset != 32'hFFFF_FFFF)
				offset++;

			// Resolve the final status by priority on the last byte
			if (last) begin
				if (offset < MIN_FILE_BYTES)
					st = ST_SHORT;
				else if (err != ST_OK)
					st = err;
				else if (phase == PH_BODY)
					st = ST_TRUNC;
				else if (!have_fmt)
					st = ST_NO_FMT;
				else if (!have_data)
					st = ST_NO_DATA;
				else if (fmt_lo[15:0] != FMT_PCM || fmt_hi[63:48] != PCM_BITS ||
						fmt_lo[31:16] < MIN_CHANNELS || fmt_lo[31:16] > MAX_CHANNELS)
					st = ST_UNSUPP;
				else if (data_empty)
					st = ST_EMPTY;
				else
					st = ST_OK;
				w.done    = 1'b1;
				w.st      = st;
				w.fmt_tag = fmt_lo[15:0];
				w.chans   = fmt_lo[31:16];
				w.rate    = fmt_lo[63:32];
				w.brate   = fmt_hi[31:0];
				w.align   = fmt_hi[47:32];
				w.bits    = fmt_hi[63:48];
				rewind();
			end
			due_words.push_back(w);
		endfunction

		function void same(string name, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
				errors++;
			end
		endfunction

		// Compare a taken word against the oldest prediction
		function void check_result(wav_word_t got);
			wav_word_t want;
			if (due_words.size() == 0) begin
				$error("result word taken with no byte outstanding");
				errors++;
				return;
			end
			want = due_words.pop_front();
			same("payload_valid", 32'(want.pay_valid), 32'(got.pay_valid));
			same("payload_byte", 32'(want.pay_byte), 32'(got.pay_byte));
			same("payload_start", 32'(want.pay_start), 32'(got.pay_start));
			same("done_res", 32'(want.done), 32'(got.done));
			same("status", 32'(want.st), 32'(got.st));
			same("format_tag", 32'(want.fmt_tag), 32'(got.fmt_tag));
			same("channel_count", 32'(want.chans), 32'(got.chans));
			same("sample_rate", want.rate, got.rate);
			same("byte_rate", want.brate, got.brate);
			same("block_align", 32'(want.align), 32'(got.align));
			same("sample_bits", 32'(want.bits), 32'(got.bits));
		endfunction
	endclass

endpackage

### tb/sv/riff_wav_stream_parser_tb.sv
`timescale 1ns / 1ps
// Top of the RIFF/WAVE stream parser bench: builds directed and random WAV
// files, streams them byte by byte and checks every result word.
// Depends on rwp_pkg, wav_tb_pkg and the riff_wav_stream_parser RTL.

module riff_wav_stream_parser_tb;
	import rwp_pkg::*;
	import wav_tb_pkg::*;

	typedef enum int {
		PICK_FMT,
		PICK_DATA,
		PICK_OTHER
	} chunk_pick_e;

	localparam logic [31:0] TAG_LIST = 32'h5453_494C;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  file_byte = 8'd0;
	logic        is_last   = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        payload_start;
	logic        done_res;
	logic [3:0]  status;
	logic [15:0] format_tag;
	logic [15:0] channel_count;
	logic [31:0] sample_rate;
	logic [31:0] byte_rate;
	logic [15:0] block_align;
	logic [15:0] sample_bits;

	wav_result_board sb;
	wav_word_t       taken_word;
	logic [7:0]      file_q[$];
	int              send_gap_pct   = 14;
	int              recv_stall_pct = 69;

	riff_wav_stream_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.file_byte     (file_byte),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.payload_start (payload_start),
		.done_res      (done_res),
		.status        (status),
		.format_tag    (format_tag),
		.channel_count (channel_count),
		.sample_rate   (sample_rate),
		.byte_rate     (byte_rate),
		.block_align   (block_align),
		.sample_bits   (sample_bits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the output at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Check every result word the receiver takes
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			taken_word = {payload_valid, payload_byte, payload_start, done_res, status,
				format_tag, channel_count, sample_rate, byte_rate, block_align,
				sample_bits};
			sb.check_result(taken_word);
		end
	end

	// Append n bytes of v, low byte first
	function automatic void put_le(logic [31:0] v, int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(v[8*i +: 8]);
	endfunction

	// Start a file with its RIFF and WAVE tags, optionally with a flipped bit
	function automatic void put_riff(bit bad_riff, bit bad_wave);
		file_q.delete();
		put_le(bad_riff ? TAG_RIFF ^ (32'h1 << $urandom_range(31)) : TAG_RIFF, 4);
		put_le($urandom, 4);
		put_le(bad_wave ? TAG_WAVE ^ (32'h1 << $urandom_range(31)) : TAG_WAVE, 4);
	endfunction

	// Chunk with random body; the pad goes in only when the body is complete
	function automatic void put_chunk(logic [31:0] id, logic [31:0] size, int body_n);
		put_le(id, 4);
		put_le(size, 4);
		repeat (body_n)
			file_q.push_back(8'($urandom));
		if (size[0] && body_n == size)
			file_q.push_back(8'($urandom));
	endfunction

	function automatic void put_fmt(int unsigned sz, logic [15:0] tag, logic [15:0] ch,
			logic [31:0] rate, logic [31:0] brate, logic [15:0] align, logic [15:0] bits);
		put_le(TAG_FMT, 4);
		put_le(sz, 4);
		if (sz >= FMT_MIN_SIZE) begin
			put_le(32'(tag), 2);
			put_le(32'(ch), 2);
			put_le(rate, 4);
			put_le(brate, 4);
			put_le(32'(align), 2);
			put_le(32'(bits), 2);
			repeat (sz - FMT_MIN_SIZE)
				file_q.push_back(8'($urandom));
		end else begin
			repeat (sz)
				file_q.push_back(8'($urandom));
		end
		if (sz[0])
			file_q.push_back(8'($urandom));
	endfunction

	function automatic void put_pcm_fmt(logic [15:0] ch);
		put_fmt(FMT_MIN_SIZE, FMT_PCM, ch, 32'd44100, 32'd44100 * 2 * ch, 16'(2 * ch),
			PCM_BITS);
	endfunction

	// Offer one word and hold it until taken
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		file_byte <= b;
		is_last   <= last;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_byte(b, last);
	endtask

	task automatic send_file();
		foreach (file_q[i])
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	// Hold off the sender until every predicted word has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		int v;
		// small good file: mono, extreme rates, odd data with its pad
		put_riff(0, 0);
		put_fmt(FMT_MIN_SIZE, FMT_PCM, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
			PCM_BITS);
		put_le(TAG_DATA, 4);
		put_le(32'd3, 4);
		file_q.push_back(8'h00);
		file_q.push_back(8'hFF);
		file_q.push_back(8'h80);
		file_q.push_back(8'h5A);
		send_file();

		// file of a single byte
		file_q.delete();
		file_q.push_back(8'h52);
		send_file();

		// one byte under the minimum length
		put_riff(0, 0);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 0, 0);
		void'(file_q.pop_back());
		send_file();

		// exactly the minimum length, data chunk empty
		put_riff(0, 0);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 0, 0);
		send_file();

		// bad RIFF tag, then bad WAVE tag
		put_riff(1, 0);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 8, 8);
		send_file();
		put_riff(0, 1);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 8, 8);
		send_file();

		// fmt chunk too small: data after it must not come out
		put_riff(0, 0);
		put_chunk(TAG_FMT, 14, 14);
		put_chunk(TAG_DATA, 12, 12);
		send_file();

		// fmt chunk of size zero
		put_riff(0, 0);
		put_chunk(TAG_FMT, 0, 0);
		put_chunk(TAG_DATA, 30, 30);
		send_file();

		// data payload cut off by the end of file
		put_riff(0, 0);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 100, 20);
		send_file();

		// maximum chunk size
		put_riff(0, 0);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 32'hFFFF_FFFF, 10);
		send_file();

		// small fmt chunk cut off by the end of file reads as truncated
		put_riff(0, 0);
		put_chunk(TAG_DATA, 20, 20);
		put_chunk(TAG_FMT, 15, 5);
		send_file();

		// no fmt chunk, odd-sized other chunk before the data
		put_riff(0, 0);
		put_chunk(TAG_LIST, 5, 5);
		put_chunk(TAG_DATA, 30, 30);
		send_file();

		// no data chunk
		put_riff(0, 0);
		put_pcm_fmt(16'd1);
		put_chunk(TAG_LIST, 20, 20);
		send_file();

		// unsupported: float tag, zero channels, three channels, 8-bit samples
		for (v = 0; v < 4; v++) begin
			put_riff(0, 0);
			put_fmt(FMT_MIN_SIZE, v == 0 ? 16'd3 : FMT_PCM,
				v == 1 ? 16'd0 : (v == 2 ? 16'd3 : 16'd2),
				32'd48000, 32'd192000, 16'd4, v == 3 ? 16'd8 : PCM_BITS);
			put_chunk(TAG_DATA, 4, 4);
			send_file();
		end

		// last data chunk empty after a full one
		put_riff(0, 0);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 6, 6);
		put_chunk(TAG_DATA, 0, 0);
		send_file();

		// later fmt wins over a bad one with extra bytes; two data starts
		put_riff(0, 0);
		put_fmt(18, 16'd3, 16'd6, 32'd8000, 32'd16000, 16'd2, 16'd24);
		put_chunk(TAG_DATA, 3, 3);
		put_pcm_fmt(16'd1);
		put_chunk(TAG_DATA, 5, 5);
		send_file();

		// partial chunk header at the end is ignored
		put_riff(0, 0);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 4, 4);
		repeat (7)
			file_q.push_back(8'($urandom));
		send_file();

		// missing final pad is ignored
		put_riff(0, 0);
		put_pcm_fmt(16'd2);
		put_chunk(TAG_DATA, 5, 5);
		void'(file_q.pop_back());
		send_file();
	endtask

	function automatic void put_random_fmt();
		int          r;
		int unsigned sz;
		logic [15:0] tag;
		logic [15:0] ch;
		logic [15:0] bits;
		r  = $urandom_range(99);
		sz = (r < 80) ? FMT_MIN_SIZE : (r < 90 ? $urandom_range(20, 17) : $urandom_range(15));
		if ($urandom_range(99) < 85) begin
			tag  = FMT_PCM;
			ch   = 16'($urandom_range(2, 1));
			bits = PCM_BITS;
		end else begin
			tag  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
			ch   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
			bits = $urandom_range(1) ? 16'($urandom) : 16'(8 * $urandom_range(4, 1));
		end
		put_fmt(sz, tag, ch, $urandom, $urandom, 16'($urandom), bits);
	endfunction

	function automatic void put_random_data();
		int          r;
		logic [31:0] sz;
		r = $urandom_range(99);
		if (r < 10) begin
			put_chunk(TAG_DATA, 0, 0);
		end else if (r < 13) begin
			sz = $urandom | 32'h0000_0100;
			put_chunk(TAG_DATA, sz, $urandom_range(12, 1));
		end else begin
			sz = $urandom_range(24, 1);
			put_chunk(TAG_DATA, sz, sz);
		end
	endfunction

	// Mostly well-formed files with random content, some broken, some noise
	function automatic void make_random_file();
		int          sel;
		int          n_chunks;
		int          cut;
		int          r;
		logic [31:0] sz;
		chunk_pick_e pick;
		sel = $urandom_range(99);
		if (sel < 8) begin
			file_q.delete();
			if ($urandom_range(1))
				put_riff(0, 0);
			repeat ($urandom_range(50, 1))
				file_q.push_back(8'($urandom));
			return;
		end
		put_riff(sel < 11, sel >= 11 && sel < 13);
		n_chunks = $urandom_range(5, 2);
		for (int i = 0; i < n_chunks; i++) begin
			if (i == 0 && $urandom_range(99) < 85)
				pick = PICK_FMT;
			else if (i == n_chunks - 1 && $urandom_range(99) < 85)
				pick = PICK_DATA;
			else
				pick = chunk_pick_e'($urandom_range(2));
			case (pick)
				PICK_FMT: begin
					put_random_fmt();
				end
				PICK_DATA: begin
					put_random_data();
				end
				default: begin
					sz = $urandom_range(9);
					put_chunk($urandom, sz, sz);
				end
			endcase
		end
		// cut the tail or append a stray partial header
		r = $urandom_range(99);
		if (r < 10) begin
			cut = $urandom_range(12, 1);
			while (cut > 0 && file_q.size() > 1) begin
				void'(file_q.pop_back());
				cut--;
			end
		end else if (r < 20) begin
			repeat ($urandom_range(7, 1))
				file_q.push_back(8'($urandom));
		end
	endfunction

	initial begin
		int sent;
		sb = new();
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// three idle profiles: sender light, receiver light, then none
		for (int p = 0; p < 3; p++) begin
			send_gap_pct   = (p == 0) ? 14 : (p == 1 ? 69 : 0);
			recv_stall_pct = (p == 0) ? 69 : (p == 1 ? 14 : 0);
			sent = 0;
			while (sent < 20) begin
				make_random_file();
				sent += file_q.size();
				send_file();
			end
			drain();
		end

		repeat (16)
			@(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
